### sv/per_slot_frame_statistics_top_defines.svh
// Assertion macros shared by the per-slot frame statistics block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef PER_SLOT_FRAME_STATISTICS_TOP_DEFINES_SVH
`define PER_SLOT_FRAME_STATISTICS_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/psfs_pkg.sv
// Package for the per-slot frame statistics block: field widths, operation
// and command codes, register indexes and the command record. No dependencies.
package psfs_pkg;

  localparam int OP_W        = 3;
  localparam int SLOT_W      = 6;
  localparam int SLOT_EXT_W  = 8;
  localparam int AMOUNT_W    = 32;
  localparam int TIME_W      = 48;
  localparam int CALLS_W     = 48;
  localparam int SUM_W       = 64;
  localparam int FRAMES_W    = 32;
  localparam int CFG_SLOTS_W = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 296;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 3'd0,
    OP_COUNT  = 3'd1,
    OP_BEGIN  = 3'd2,
    OP_END    = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_SAMPLE,
    KIND_COUNT,
    KIND_BEGIN,
    KIND_END,
    KIND_CLEAR,
    KIND_READ
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b1;

  typedef struct packed {
    kind_t                   kind;
    logic [SLOT_W-1:0]       slot;
    logic [AMOUNT_W-1:0]     amount;
    logic [CFG_SLOTS_W-1:0]  slots_in_use;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

### sv/per_slot_frame_statistics_top.sv
// Top level of the per-slot frame statistics block: joins the front end and
// the back end and checks their hand-off. Uses psfs_pkg, psfs_front, psfs_back
// and per_slot_frame_statistics_top_defines.svh.
//
//  Channel | Ports                              | Fields, lowest bit first
//  in      | in_tvalid in_tready in_tdata[47:0] | operation, slot, amount
//  out     | out_tvalid out_tready out_tdata    | accepted .. frame_total
//  cfg     | cfg_we cfg_index cfg_wdata         | enabled, slots_in_use
//
// Sample, count and read go through the access state of the back end;
// begin-frame, clear and ignored operations finish when popped; end-frame
// walks the slots in use one at a time through the single registered read
// port of the slot memories. Per-slot valid bits stand in for clearing them.
// A two-entry queue keeps taking items while a result waits on out_tready.
`include "per_slot_frame_statistics_top_defines.svh"

module per_slot_frame_statistics_top #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [psfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // operation [2:0], slot [8:3], amount [40:9], zero fill [47:41]
  input  logic [psfs_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // accepted [0], total_nanos [64:1], total_calls [128:65],
  // min_frame_nanos [176:129], max_frame_nanos [224:177],
  // sampled_frames [256:225], frame_total [288:257], zero fill [295:289]
  output logic [psfs_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic                   cmd_valid;
  logic                   cmd_ready;
  psfs_pkg::cmd_t         cmd;
  psfs_pkg::back_status_t bk_status;

  psfs_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  psfs_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .status     (bk_status)
  );

  `PSFS_ASSERT_NOW(a_full_queue_offers, !in_tready, cmd_valid, "Full queue offers no command.")
  `PSFS_ASSERT_NOW(a_pop_needs_out, cmd_valid && cmd_ready, !out_tvalid || out_tready, "Command taken while result register is held.")
  `PSFS_ASSERT_NEXT(a_pop_makes_work, cmd_valid && cmd_ready, out_tvalid || bk_status.busy, "Taken command left no work and no result.")
  `PSFS_ASSERT_NOW(a_result_has_cause, $rose(out_tvalid), $past(bk_status.busy) || $past(cmd_valid && cmd_ready), "Result appeared without a command.")

endmodule

### sv/psfs_front.sv
// Front end of the per-slot frame statistics block: configuration registers,
// input decode into commands and a two-entry command queue. Uses psfs_pkg.
module psfs_front #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [psfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [psfs_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output psfs_pkg::cmd_t                    cmd
);

  logic                              enabled_r;
  logic [psfs_pkg::CFG_SLOTS_W-1:0]  slots_in_use_r;

  psfs_pkg::cmd_t                    q_r [2];
  logic                              wr_ptr_r;
  logic                              rd_ptr_r;
  logic [1:0]                        cnt_r;

  psfs_pkg::op_t                     op;
  logic [psfs_pkg::SLOT_W-1:0]       slot;
  logic [psfs_pkg::AMOUNT_W-1:0]     amount;
  logic                              slot_ok;
  psfs_pkg::cmd_t                    cmd_nxt;
  logic                              push;
  logic                              pop;

  always_comb begin
    op      = psfs_pkg::op_t'(in_tdata[psfs_pkg::OP_W-1:0]);
    slot    = in_tdata[psfs_pkg::OP_W +: psfs_pkg::SLOT_W];
    amount  = in_tdata[psfs_pkg::OP_W + psfs_pkg::SLOT_W +: psfs_pkg::AMOUNT_W];
    slot_ok = int'(slot) < MAX_SLOTS;

    cmd_nxt.slot         = slot;
    cmd_nxt.amount       = amount;
    cmd_nxt.slots_in_use = slots_in_use_r;
    unique case (op)
      psfs_pkg::OP_SAMPLE: begin
        cmd_nxt.kind = slot_ok ? psfs_pkg::KIND_SAMPLE : psfs_pkg::KIND_NOP;
      end
      psfs_pkg::OP_COUNT: begin
        cmd_nxt.kind = (slot_ok && enabled_r) ? psfs_pkg::KIND_COUNT : psfs_pkg::KIND_NOP;
      end
      psfs_pkg::OP_BEGIN: begin
        cmd_nxt.kind = enabled_r ? psfs_pkg::KIND_BEGIN : psfs_pkg::KIND_NOP;
      end
      psfs_pkg::OP_END: begin
        cmd_nxt.kind = enabled_r ? psfs_pkg::KIND_END : psfs_pkg::KIND_NOP;
      end
      psfs_pkg::OP_CLEAR: begin
        cmd_nxt.kind = psfs_pkg::KIND_CLEAR;
      end
      psfs_pkg::OP_READ: begin
        cmd_nxt.kind = slot_ok ? psfs_pkg::KIND_READ : psfs_pkg::KIND_NOP;
      end
      default: begin
        cmd_nxt.kind = psfs_pkg::KIND_NOP;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r      <= 1'b1;
      slots_in_use_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psfs_pkg::CFG_ENABLED:      enabled_r      <= cfg_wdata[0];
        psfs_pkg::CFG_SLOTS_IN_USE: slots_in_use_r <= cfg_wdata[psfs_pkg::CFG_SLOTS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      priority if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

endmodule

### sv/psfs_back.sv
// Back end of the per-slot frame statistics block: slot memories with valid
// bits, the command sequencer with the end-frame walk and the result register.
// Uses psfs_pkg.
module psfs_back #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  psfs_pkg::cmd_t                    cmd,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [psfs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output psfs_pkg::back_status_t            status
);

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int NW = (CW > psfs_pkg::CFG_SLOTS_W) ? CW : psfs_pkg::CFG_SLOTS_W;
  localparam int PAD_W = psfs_pkg::OUT_DATA_W - 1 - 2 * psfs_pkg::SUM_W
                         - 2 * psfs_pkg::TIME_W - 2 * psfs_pkg::FRAMES_W;

  typedef struct packed {
    logic [psfs_pkg::TIME_W-1:0]  frame_time;
    logic [psfs_pkg::CALLS_W-1:0] frame_calls;
  } frame_acc_t;

  typedef struct packed {
    logic [psfs_pkg::SUM_W-1:0]    sum_time;
    logic [psfs_pkg::SUM_W-1:0]    sum_calls;
    logic [psfs_pkg::TIME_W-1:0]   least_time;
    logic [psfs_pkg::TIME_W-1:0]   greatest_time;
    logic [psfs_pkg::FRAMES_W-1:0] frames_sampled;
  } slot_stats_t;

  typedef struct packed {
    logic [PAD_W-1:0]              pad;
    logic [psfs_pkg::FRAMES_W-1:0] frame_total;
    logic [psfs_pkg::FRAMES_W-1:0] sampled_frames;
    logic [psfs_pkg::TIME_W-1:0]   max_frame_nanos;
    logic [psfs_pkg::TIME_W-1:0]   min_frame_nanos;
    logic [psfs_pkg::SUM_W-1:0]    total_calls;
    logic [psfs_pkg::SUM_W-1:0]    total_nanos;
    logic                          accepted;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_WALK
  } state_t;

  frame_acc_t                      frame_mem [MAX_SLOTS];
  slot_stats_t                     stat_mem  [MAX_SLOTS];
  frame_acc_t                      frame_rd_r;
  slot_stats_t                     stat_rd_r;

  state_t                          state_r;
  psfs_pkg::cmd_t                  cur_r;
  logic [SW-1:0]                   wk_r;
  logic [CW-1:0]                   n_r;
  logic [MAX_SLOTS-1:0]            frame_vld_r;
  logic [MAX_SLOTS-1:0]            stat_vld_r;
  logic [psfs_pkg::FRAMES_W-1:0]   frames_seen_r;
  logic                            out_valid_r;
  result_t                         out_data_r;

  logic                            out_free;
  logic                            pop;
  logic                            res_load;
  logic [psfs_pkg::SLOT_EXT_W-1:0] head_ext;
  logic [psfs_pkg::SLOT_EXT_W-1:0] cur_ext;
  logic [SW-1:0]                   head_idx;
  logic [SW-1:0]                   cur_idx;
  logic [NW-1:0]                   siu_ext;
  logic [CW-1:0]                   walk_n_head;
  logic [MAX_SLOTS-1:0]            clr_mask;
  logic [SW-1:0]                   rd_addr;
  logic                            walk_last;

  logic [psfs_pkg::TIME_W-1:0]     acc_time;
  logic [psfs_pkg::CALLS_W-1:0]    acc_calls;
  frame_acc_t                      frame_wr;
  logic                            frame_we;

  logic [psfs_pkg::TIME_W-1:0]     fold_time;
  logic [psfs_pkg::CALLS_W-1:0]    fold_calls;
  slot_stats_t                     fold_old;
  slot_stats_t                     stat_wr;
  logic                            stat_we;
  slot_stats_t                     read_stats;

  assign out_free  = !out_valid_r || out_tready;
  assign cmd_ready = (state_r == ST_IDLE) && out_free;
  assign pop       = cmd_valid && cmd_ready;

  assign head_ext = psfs_pkg::SLOT_EXT_W'(cmd.slot);
  assign head_idx = head_ext[SW-1:0];
  assign cur_ext  = psfs_pkg::SLOT_EXT_W'(cur_r.slot);
  assign cur_idx  = cur_ext[SW-1:0];

  always_comb begin
    siu_ext     = NW'(cmd.slots_in_use);
    walk_n_head = (siu_ext < NW'(MAX_SLOTS)) ? CW'(siu_ext) : CW'(MAX_SLOTS);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      clr_mask[i] = CW'(i) < walk_n_head;
    end
  end

  assign walk_last = !((CW'(wk_r) + CW'(1)) < n_r);

  // A result is loaded when an access or a walk finishes, or when a popped
  // command completes at once, needing neither an access nor a walk.
  always_comb begin
    priority if (state_r == ST_ACCESS) begin
      res_load = 1'b1;
    end else if (state_r == ST_WALK) begin
      res_load = walk_last;
    end else if (pop) begin
      res_load = (cmd.kind != psfs_pkg::KIND_SAMPLE) &&
                 (cmd.kind != psfs_pkg::KIND_COUNT) &&
                 (cmd.kind != psfs_pkg::KIND_READ) &&
                 !(cmd.kind == psfs_pkg::KIND_END && walk_n_head != '0);
    end else begin
      res_load = 1'b0;
    end
  end

  always_comb begin
    priority if (state_r == ST_WALK) begin
      rd_addr = wk_r + SW'(1);
    end else if (cmd.kind == psfs_pkg::KIND_END) begin
      rd_addr = '0;
    end else begin
      rd_addr = head_idx;
    end
  end

  // Sample and count update the per-frame accumulators of the current slot.
  always_comb begin
    acc_time  = frame_vld_r[cur_idx] ? frame_rd_r.frame_time  : '0;
    acc_calls = frame_vld_r[cur_idx] ? frame_rd_r.frame_calls : '0;
    if (cur_r.kind == psfs_pkg::KIND_SAMPLE) begin
      frame_wr.frame_time  = acc_time + psfs_pkg::TIME_W'(cur_r.amount);
      frame_wr.frame_calls = acc_calls + psfs_pkg::CALLS_W'(1);
    end else begin
      frame_wr.frame_time  = acc_time;
      frame_wr.frame_calls = acc_calls + psfs_pkg::CALLS_W'(cur_r.amount);
    end
    frame_we = (state_r == ST_ACCESS) &&
               (cur_r.kind == psfs_pkg::KIND_SAMPLE || cur_r.kind == psfs_pkg::KIND_COUNT);
  end

  // End-frame fold of the slot whose data returns in this cycle.
  always_comb begin
    fold_time  = frame_vld_r[wk_r] ? frame_rd_r.frame_time  : '0;
    fold_calls = frame_vld_r[wk_r] ? frame_rd_r.frame_calls : '0;
    fold_old   = stat_vld_r[wk_r]  ? stat_rd_r : '0;
    stat_wr.sum_time  = fold_old.sum_time  + psfs_pkg::SUM_W'(fold_time);
    stat_wr.sum_calls = fold_old.sum_calls + psfs_pkg::SUM_W'(fold_calls);
    stat_wr.least_time = (fold_old.frames_sampled == '0 || fold_time < fold_old.least_time) ?
                         fold_time : fold_old.least_time;
    stat_wr.greatest_time = (fold_time > fold_old.greatest_time) ?
                            fold_time : fold_old.greatest_time;
    stat_wr.frames_sampled = fold_old.frames_sampled + psfs_pkg::FRAMES_W'(1);
    stat_we = (state_r == ST_WALK) && (fold_calls != '0);
  end

  assign read_stats = stat_vld_r[cur_idx] ? stat_rd_r : '0;

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[cur_idx] <= frame_wr;
    end
    frame_rd_r <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[wk_r] <= stat_wr;
    end
    stat_rd_r <= stat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cur_r         <= '0;
      wk_r          <= '0;
      n_r           <= '0;
      frame_vld_r   <= '0;
      stat_vld_r    <= '0;
      frames_seen_r <= '0;
      out_valid_r   <= 1'b0;
      out_data_r    <= '0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            cur_r <= cmd;
            unique case (cmd.kind)
              psfs_pkg::KIND_SAMPLE, psfs_pkg::KIND_COUNT, psfs_pkg::KIND_READ: begin
                state_r <= ST_ACCESS;
              end
              psfs_pkg::KIND_BEGIN: begin
                frame_vld_r <= frame_vld_r & ~clr_mask;
                out_data_r  <= '{accepted: 1'b1, default: '0};
              end
              psfs_pkg::KIND_CLEAR: begin
                frame_vld_r   <= frame_vld_r & ~clr_mask;
                stat_vld_r    <= stat_vld_r & ~clr_mask;
                frames_seen_r <= '0;
                out_data_r    <= '{accepted: 1'b1, default: '0};
              end
              psfs_pkg::KIND_END: begin
                if (walk_n_head == '0) begin
                  frames_seen_r <= frames_seen_r + psfs_pkg::FRAMES_W'(1);
                  out_data_r    <= '{accepted: 1'b1, default: '0};
                end else begin
                  wk_r    <= '0;
                  n_r     <= walk_n_head;
                  state_r <= ST_WALK;
                end
              end
              default: begin
                out_data_r <= '0;
              end
            endcase
          end
        end
        ST_ACCESS: begin
          state_r <= ST_IDLE;
          if (cur_r.kind == psfs_pkg::KIND_READ) begin
            out_data_r <= '{pad:             '0,
                            frame_total:     frames_seen_r,
                            sampled_frames:  read_stats.frames_sampled,
                            max_frame_nanos: read_stats.greatest_time,
                            min_frame_nanos: read_stats.least_time,
                            total_calls:     read_stats.sum_calls,
                            total_nanos:     read_stats.sum_time,
                            accepted:        1'b1};
          end else begin
            frame_vld_r[cur_idx] <= 1'b1;
            out_data_r           <= '{accepted: 1'b1, default: '0};
          end
        end
        ST_WALK: begin
          if (stat_we) begin
            stat_vld_r[wk_r] <= 1'b1;
          end
          if (walk_last) begin
            state_r       <= ST_IDLE;
            frames_seen_r <= frames_seen_r + psfs_pkg::FRAMES_W'(1);
            out_data_r    <= '{accepted: 1'b1, default: '0};
          end else begin
            wk_r <= wk_r + SW'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign status.busy = (state_r != ST_IDLE);

endmodule
